// ===== rtl/dsh_pkg.sv =====
// Shared types and constants for the diamond-square heightmap core.
`default_nettype none

package dsh_pkg;

	typedef enum logic [2:0] {
		PH_C0      = 3'd0,
		PH_C1      = 3'd1,
		PH_C2      = 3'd2,
		PH_C3      = 3'd3,
		PH_DIAMOND = 3'd4,
		PH_SQUARE  = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	typedef struct packed {
		logic       accept;
		logic       rd_en;
		logic [1:0] rd_idx;
		logic       calc;
		logic       write;
	} dsh_cmd_t;

	typedef struct packed {
		logic out_free;
	} dsh_stat_t;

	localparam int unsigned SIZE_W      = 4;
	localparam int unsigned DRAW_W      = 9;
	localparam int unsigned POS_W       = 9;
	localparam int unsigned HEIGHT_W    = 8;
	localparam int unsigned SUM_W       = 10;
	localparam int unsigned CNT_W       = 3;
	localparam int unsigned DIV3_MUL    = 683;
	localparam int unsigned DIV3_SHIFT  = 11;
	localparam int unsigned DIV3_W      = SUM_W + 10;
	localparam logic [7:0]  FULL_AMP    = 8'd128;
	localparam logic [7:0]  HEIGHT_MAX  = 8'd255;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/diamond_square_heightmap_core.sv =====
// Top level: diamond-square heightmap core, one grid point per input beat.
// Each beat is sequenced as four reads of the single map memory port, a drain state for the
// registered read, an averaging state and a write-back; no new beat is taken before write-back.
// The result beat is registered at write-back and waits in an output register; the write-back
// state holds while that register is full and not taken.
// Asynchronous active-low reset clears control state; map memory contents are not cleared.
`default_nettype none

module diamond_square_heightmap_core #(
	parameter int unsigned MAX_LOG2 = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [dsh_pkg::DRAW_W-1:0] draw,
	input  wire logic                        restart,
	input  wire logic                        cfg_we,
	input  wire logic [dsh_pkg::SIZE_W-1:0]  cfg_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [dsh_pkg::POS_W-1:0]        x_pos,
	output logic [dsh_pkg::POS_W-1:0]        y_pos,
	output logic [dsh_pkg::HEIGHT_W-1:0]     height,
	output logic [7:0]                       next_amplitude,
	output logic                             last
);

	dsh_pkg::dsh_cmd_t  cmd;
	dsh_pkg::dsh_stat_t stat;

	dsh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsh_datapath #(
		.MAX_LOG2 (MAX_LOG2)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.draw           (draw),
		.restart        (restart),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.x_pos          (x_pos),
		.y_pos          (y_pos),
		.height         (height),
		.next_amplitude (next_amplitude),
		.last           (last)
	);

endmodule

`default_nettype wire

// ===== rtl/dsh_ctrl.sv =====
// Controller state machine sequencing neighbor reads, averaging and write-back.
`default_nettype none

module dsh_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dsh_pkg::dsh_stat_t stat,
	output dsh_pkg::dsh_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_CALC,
		ST_WRITE
	} state_t;

	state_t     state_q;
	logic [1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= 2'd0;
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.accept = (state_q == ST_IDLE) && in_valid;
	assign cmd.rd_en  = (state_q == ST_READ);
	assign cmd.rd_idx = idx_q;
	assign cmd.calc   = (state_q == ST_CALC);
	assign cmd.write  = (state_q == ST_WRITE) && stat.out_free;

endmodule

`default_nettype wire

// ===== rtl/dsh_datapath.sv =====
// Datapath: map memory, traversal registers, neighbor averaging and output register.
`default_nettype none

module dsh_datapath #(
	parameter int unsigned MAX_LOG2 = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dsh_pkg::dsh_cmd_t           cmd,
	output dsh_pkg::dsh_stat_t               stat,
	input  wire logic signed [dsh_pkg::DRAW_W-1:0] draw,
	input  wire logic                        restart,
	input  wire logic                        cfg_we,
	input  wire logic [dsh_pkg::SIZE_W-1:0]  cfg_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [dsh_pkg::POS_W-1:0]        x_pos,
	output logic [dsh_pkg::POS_W-1:0]        y_pos,
	output logic [dsh_pkg::HEIGHT_W-1:0]     height,
	output logic [7:0]                       next_amplitude,
	output logic                             last
);

	localparam int unsigned CW    = MAX_LOG2 + 2;
	localparam int unsigned LW    = $clog2(MAX_LOG2 + 1);
	localparam int unsigned GRID  = (1 << MAX_LOG2) + 1;
	localparam int unsigned DEPTH = GRID * GRID;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned EW    = CW + dsh_pkg::POS_W;
	localparam int unsigned RST_LOG2 = (MAX_LOG2 < 8) ? MAX_LOG2 : 8;

	logic [dsh_pkg::SIZE_W-1:0] size_q;
	logic [LW-1:0]              cur_q;
	logic [CW-1:0]              step_q;
	logic [CW-1:0]              col_q;
	logic [CW-1:0]              row_q;
	dsh_pkg::phase_t            phase_q;
	logic [7:0]                 amp_q;
	logic signed [dsh_pkg::DRAW_W-1:0] draw_q;
	logic [dsh_pkg::SUM_W-1:0]  sum_q;
	logic [dsh_pkg::CNT_W-1:0]  cnt_q;
	logic [7:0]                 avg_q;
	logic [7:0]                 rdata_s1;
	logic                       acc_s1;
	logic [7:0]                 mem [DEPTH];

	logic [LW-1:0]  clamp_log2;
	logic [CW-1:0]  half;
	logic [CW-1:0]  side;
	logic [CW-1:0]  xm;
	logic [CW-1:0]  xp;
	logic [CW-1:0]  ym;
	logic [CW-1:0]  yp;
	logic           x_lo_ok;
	logic           x_hi_ok;
	logic           y_lo_ok;
	logic           y_hi_ok;
	logic [CW-1:0]  nx;
	logic [CW-1:0]  ny;
	logic           nb_ok;
	logic           rd_ok;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic           start_map;

	logic [dsh_pkg::DIV3_W-1:0] prod3;
	logic [7:0]                 avg_d;

	logic signed [9:0] d10;
	logic signed [9:0] a10;
	logic signed [9:0] off;
	logic signed [9:0] val;
	logic [7:0]        h;
	logic [CW-1:0]     wx;
	logic [CW-1:0]     wy;
	logic [CW-1:0]     nc;
	logic [CW-1:0]     nr;
	logic [CW-1:0]     step_half;
	logic [CW-1:0]     col_d;
	logic [CW-1:0]     row_d;
	logic [CW-1:0]     step_d;
	logic [7:0]        amp_d;
	dsh_pkg::phase_t   phase_d;
	logic              last_d;
	logic [EW-1:0]     wx_ext;
	logic [EW-1:0]     wy_ext;

	always_comb begin
		if (size_q == '0) begin
			clamp_log2 = LW'(1);
		end else if (32'(size_q) > MAX_LOG2) begin
			clamp_log2 = LW'(MAX_LOG2);
		end else begin
			clamp_log2 = LW'(size_q);
		end
	end

	assign start_map = restart || (phase_q == dsh_pkg::PH_C0) || (phase_q == dsh_pkg::PH_DONE);

	assign half = step_q >> 1;
	assign side = (CW'(1) << cur_q) + CW'(1);

	assign xm      = col_q - half;
	assign xp      = col_q + half;
	assign ym      = row_q - half;
	assign yp      = row_q + half;
	assign x_lo_ok = (col_q >= half);
	assign x_hi_ok = (xp < side);
	assign y_lo_ok = (row_q >= half);
	assign y_hi_ok = (yp < side);

	always_comb begin
		nx    = col_q;
		ny    = row_q;
		nb_ok = 1'b0;
		if (phase_q == dsh_pkg::PH_DIAMOND) begin
			nx    = cmd.rd_idx[0] ? xp : xm;
			ny    = cmd.rd_idx[1] ? yp : ym;
			nb_ok = (cmd.rd_idx[0] ? x_hi_ok : x_lo_ok) && (cmd.rd_idx[1] ? y_hi_ok : y_lo_ok);
		end else begin
			case (cmd.rd_idx)
				2'd0: begin
					ny    = ym;
					nb_ok = y_lo_ok;
				end
				2'd1: begin
					nx    = xm;
					nb_ok = x_lo_ok;
				end
				2'd2: begin
					ny    = yp;
					nb_ok = y_hi_ok;
				end
				default: begin
					nx    = xp;
					nb_ok = x_hi_ok;
				end
			endcase
		end
	end

	assign rd_ok   = nb_ok && ((phase_q == dsh_pkg::PH_DIAMOND) || (phase_q == dsh_pkg::PH_SQUARE));
	assign rd_addr = (AW'(ny[MAX_LOG2:0]) << MAX_LOG2) + AW'(ny[MAX_LOG2:0]) + AW'(nx[MAX_LOG2:0]);

	assign prod3 = dsh_pkg::DIV3_W'(sum_q) * dsh_pkg::DIV3_W'(dsh_pkg::DIV3_MUL);

	always_comb begin
		case (cnt_q)
			3'd4:    avg_d = 8'(sum_q >> 2);
			3'd3:    avg_d = 8'(prod3 >> dsh_pkg::DIV3_SHIFT);
			3'd2:    avg_d = 8'(sum_q >> 1);
			3'd1:    avg_d = 8'(sum_q);
			default: avg_d = 8'd0;
		endcase
	end

	assign d10 = 10'(draw_q);
	assign a10 = signed'({2'b00, amp_q});

	always_comb begin
		if (d10 > a10) begin
			off = a10;
		end else if (d10 < -a10) begin
			off = -a10;
		end else begin
			off = d10;
		end
	end

	assign val = signed'({2'b00, avg_q}) + off;

	always_comb begin
		wx        = col_q;
		wy        = row_q;
		col_d     = col_q;
		row_d     = row_q;
		step_d    = step_q;
		amp_d     = amp_q;
		phase_d   = phase_q;
		last_d    = 1'b0;
		nc        = col_q + step_q;
		nr        = '0;
		step_half = step_q >> 1;
		h         = 8'd0;
		case (phase_q)
			dsh_pkg::PH_C0, dsh_pkg::PH_C1, dsh_pkg::PH_C2, dsh_pkg::PH_C3: begin
				wx      = ((phase_q == dsh_pkg::PH_C1) || (phase_q == dsh_pkg::PH_C3)) ?
					side - CW'(1) : '0;
				wy      = ((phase_q == dsh_pkg::PH_C2) || (phase_q == dsh_pkg::PH_C3)) ?
					side - CW'(1) : '0;
				h       = draw_q[dsh_pkg::DRAW_W-1] ? 8'd0 : draw_q[7:0];
				phase_d = dsh_pkg::phase_t'(phase_q + 3'd1);
				if (phase_q == dsh_pkg::PH_C3) begin
					col_d = half;
					row_d = half;
				end
			end
			default: begin
				if (val < 10'sd0) begin
					h = 8'd0;
				end else if (val > signed'({2'b00, dsh_pkg::HEIGHT_MAX})) begin
					h = dsh_pkg::HEIGHT_MAX;
				end else begin
					h = val[7:0];
				end
				col_d = nc;
				if (nc >= side) begin
					if (phase_q == dsh_pkg::PH_DIAMOND) begin
						nr    = row_q + step_q;
						col_d = half;
						if (nr >= side) begin
							phase_d = dsh_pkg::PH_SQUARE;
							row_d   = '0;
						end else begin
							row_d = nr;
						end
					end else begin
						nr = row_q + half;
						if (nr >= side) begin
							step_d = step_half;
							amp_d  = amp_q >> 1;
							if (step_half <= CW'(1)) begin
								last_d  = 1'b1;
								phase_d = dsh_pkg::PH_DONE;
								amp_d   = dsh_pkg::FULL_AMP;
							end else begin
								phase_d = dsh_pkg::PH_DIAMOND;
								col_d   = step_half >> 1;
								row_d   = step_half >> 1;
							end
						end else begin
							row_d = nr;
							col_d = ((nr & (step_q - CW'(1))) == '0) ? half : '0;
						end
					end
				end
			end
		endcase
	end

	assign wr_addr = (AW'(wy[MAX_LOG2:0]) << MAX_LOG2) + AW'(wy[MAX_LOG2:0]) + AW'(wx[MAX_LOG2:0]);
	assign wx_ext  = EW'(wx);
	assign wy_ext  = EW'(wy);

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wr_addr] <= h;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			draw_q <= draw;
		end
		if (cmd.calc) begin
			avg_q <= avg_d;
		end
		if (cmd.write) begin
			x_pos          <= wx_ext[dsh_pkg::POS_W-1:0];
			y_pos          <= wy_ext[dsh_pkg::POS_W-1:0];
			height         <= h;
			next_amplitude <= amp_d;
			last           <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= dsh_pkg::SIZE_RESET;
			cur_q     <= LW'(RST_LOG2);
			step_q    <= CW'(1) << RST_LOG2;
			col_q     <= '0;
			row_q     <= '0;
			phase_q   <= dsh_pkg::PH_C0;
			amp_q     <= dsh_pkg::FULL_AMP;
			sum_q     <= '0;
			cnt_q     <= '0;
			acc_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			acc_s1 <= cmd.rd_en && rd_ok;
			if (cmd.accept) begin
				sum_q <= '0;
				cnt_q <= '0;
				if (start_map) begin
					cur_q   <= clamp_log2;
					step_q  <= CW'(1) << clamp_log2;
					col_q   <= '0;
					row_q   <= '0;
					phase_q <= dsh_pkg::PH_C0;
					amp_q   <= dsh_pkg::FULL_AMP;
				end
			end else if (acc_s1) begin
				sum_q <= sum_q + dsh_pkg::SUM_W'(rdata_s1);
				cnt_q <= cnt_q + dsh_pkg::CNT_W'(1);
			end
			if (cmd.write) begin
				col_q     <= col_d;
				row_q     <= row_d;
				step_q    <= step_d;
				amp_q     <= amp_d;
				phase_q   <= phase_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== rtl/dsh_checker.sv =====
// Port-level checker for the heightmap core and its bind to the top level.
`default_nettype none

module dsh_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [8:0] x_pos,
	input wire logic [8:0] y_pos,
	input wire logic [7:0] height,
	input wire logic [7:0] next_amplitude,
	input wire logic       last
);

	a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a beat is in flight");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(height) && $stable(x_pos)
			&& $stable(y_pos))
		else $error("stalled result beat changed");

	a_last_resets_amp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> next_amplitude == 8'd128)
		else $error("amplitude not restored after final point");

	a_amp_power_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(next_amplitude))
		else $error("amplitude is not a power of two");

endmodule

bind diamond_square_heightmap_core dsh_checker u_dsh_checker (.*);

`default_nettype wire
